>>> design/lwct_pkg.sv
// Shared types and codes for the write-cache tag table.
// Used by lwct_match_unit and lru_write_cache_tag_table; no dependencies.
package lwct_pkg;

   localparam int CMD_W    = 3;
   localparam int OBJ_W    = 16;
   localparam int CHUNK_W  = 20;
   localparam int SLOT_W   = 4;
   localparam int BYTES_W  = 16;
   localparam int STATUS_W = 2;
   localparam int STAMP_W  = 32;

   localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

   typedef enum logic [CMD_W-1:0] {
      CMD_FIND      = 3'd0,
      CMD_GET       = 3'd1,
      CMD_UPDATE    = 3'd2,
      CMD_INV_OBJ   = 3'd3,
      CMD_INV_CHUNK = 3'd4,
      CMD_FLUSH_OBJ = 3'd5,
      CMD_FLUSH_ALL = 3'd6
   } cmd_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_LRU,
      S_UPD,
      S_FIN
   } state_type;

   // one table entry as stored in the slot RAM
   typedef struct packed {
      logic [OBJ_W-1:0]   object;
      logic [CHUNK_W-1:0] chunk;
      logic [BYTES_W-1:0] bytes;
      logic               dirty;
      logic               locked;
      logic [STAMP_W-1:0] stamp;
   } slot_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                was_hit;
      logic [SLOT_W-1:0]   slot;
      logic [OBJ_W-1:0]    object;
      logic [CHUNK_W-1:0]  chunk;
      logic [BYTES_W-1:0]  bytes;
      logic                flush_item;
   } res_type;

   // compare results for the entry under evaluation
   typedef struct packed {
      logic tag_eq;
      logic key_eq;
      logic find_hit;
      logic evict_ok;
      logic flush_hit;
   } match_type;

endpackage

>>> design/lwct_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module lwct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic                                  rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> design/lwct_match_unit.sv
// Shared compare unit: evaluates one table entry against the request.
// Depends on lwct_pkg.
module lwct_match_unit (
   input  lwct_pkg::slot_type              entry,
   input  logic [lwct_pkg::OBJ_W-1:0]      object_id,
   input  logic [lwct_pkg::CHUNK_W-1:0]    chunk_index,
   input  logic                            flush_all,
   input  logic                            best_found,
   input  logic [lwct_pkg::STAMP_W-1:0]    best_stamp,
   output lwct_pkg::match_type             match
);

   logic tag_eq;
   logic key_eq;

   assign tag_eq = (entry.object == object_id);
   assign key_eq = tag_eq && (entry.chunk == chunk_index);

   always_comb begin
      match.tag_eq    = tag_eq;
      match.key_eq    = key_eq;
      match.find_hit  = key_eq && (entry.bytes != '0);
      match.evict_ok  = !entry.locked && !entry.dirty &&
                        (!best_found || (entry.stamp < best_stamp));
      // untagged dirty slots are never written out
      match.flush_hit = entry.dirty && (entry.object != '0) && (flush_all || tag_eq);
   end

endmodule

>>> design/lru_write_cache_tag_table.sv
// Top level of the LRU write-cache tag table: sequencer, slot RAM, valid bits.
// Depends on lwct_pkg, lwct_ram and lwct_match_unit.
//
//  channel | ports             | tdata / tuser
//  --------+-------------------+------------------------------------------------
//  request | req_tvalid/tready | tdata: command, object, chunk, slot, bytes,
//          |                   |        dirty, locked
//  result  | rsp_tvalid/tready | tdata: status, was_hit, slot, object, chunk,
//          | rsp_tlast         |        bytes; tuser: flush_item
//
// Find, invalidate and flush scan the slots in order (one RAM read per slot, one
// compare per cycle unless a flush stalls); get on a miss makes a match pass, then
// an LRU pass; update reads and writes one slot. One request is worked on at a time.
// Reset clears the per-slot valid bits at once; an invalid slot reads as zero.
// Each request holds in its last cycle until the output register is free; a
// flush also stalls its scan while a result waits there.
module lru_write_cache_tag_table #(
   parameter int ENTRIES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [2:0] command, [18:3] object_id, [38:19] chunk_index, [42:39] slot_index,
   // [58:43] byte_count, [59] set_dirty, [60] set_locked
   input  logic [63:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [1:0] status, [2] was_hit, [6:3] slot_out, [22:7] object_out,
   // [42:23] chunk_out, [58:43] bytes_out
   output logic [63:0] rsp_tdata,
   // [0] flush_item
   output logic        rsp_tuser,
   output logic        rsp_tlast
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int WORD_W = $bits(lwct_pkg::slot_type);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
   localparam logic [6:0] ENTRIES_L = 7'(ENTRIES);

   function automatic logic [lwct_pkg::SLOT_W-1:0] slot4(input logic [IDX_W-1:0] i);
      logic [IDX_W+3:0] t;
      t = (IDX_W + 4)'(i);
      return t[lwct_pkg::SLOT_W-1:0];
   endfunction

   lwct_pkg::state_type state_ff, state_in;
   lwct_pkg::cmd_type   cmd_ff, cmd_in;
   logic [lwct_pkg::OBJ_W-1:0]   obj_ff, obj_in;
   logic [lwct_pkg::CHUNK_W-1:0] chunk_ff, chunk_in;
   logic [lwct_pkg::BYTES_W-1:0] bytes_ff, bytes_in;
   logic                         dirty_ff, dirty_in;
   logic                         locked_ff, locked_in;
   logic [IDX_W-1:0]             idx_ff, idx_in;
   logic [lwct_pkg::STAMP_W-1:0] use_cnt_ff, use_cnt_in;
   logic [IDX_W-1:0]             best_idx_ff, best_idx_in;
   logic [lwct_pkg::STAMP_W-1:0] best_stamp_ff, best_stamp_in;
   logic                         best_found_ff, best_found_in;
   logic                         have_ff, have_in;
   lwct_pkg::res_type            res_ff, res_in;
   logic                         rsp_vld_ff, rsp_vld_in;
   lwct_pkg::res_type            rsp_ff, rsp_in;
   logic                         rsp_last_ff, rsp_last_in;
   logic [ENTRIES-1:0]           valid_ff, valid_in;
   logic                         rd_valid_ff, rd_valid_in;

   logic                  rd_en, wr_en;
   logic [IDX_W-1:0]      rd_addr, wr_addr;
   lwct_pkg::slot_type    wr_word, entry;
   logic [WORD_W-1:0]     rd_data;
   lwct_pkg::match_type   match;
   logic                  free;
   logic                  push;
   lwct_pkg::res_type     push_res;
   logic                  push_last;
   logic [lwct_pkg::STAMP_W-1:0] cnt_inc;
   logic [IDX_W-1:0]      idx_nxt;
   logic [IDX_W+3:0]      sidx_ext;

   lwct_ram #(
      .WIDTH (WORD_W),
      .DEPTH (ENTRIES)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_word),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // never-written slots read as all zeros
   assign entry = rd_valid_ff ? lwct_pkg::slot_type'(rd_data) : '0;

   lwct_match_unit u_match (
      .entry       (entry),
      .object_id   (obj_ff),
      .chunk_index (chunk_ff),
      .flush_all   (cmd_ff == lwct_pkg::CMD_FLUSH_ALL),
      .best_found  (best_found_ff),
      .best_stamp  (best_stamp_ff),
      .match       (match)
   );

   assign free     = !rsp_vld_ff || rsp_tready;
   assign cnt_inc  = use_cnt_ff + 32'd1;
   assign idx_nxt  = idx_ff + IDX_W'(1);
   assign sidx_ext = (IDX_W + 4)'(req_tdata[42:39]);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= lwct_pkg::S_IDLE;
         use_cnt_ff  <= '0;
         rsp_vld_ff  <= 1'b0;
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
         have_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         use_cnt_ff  <= use_cnt_in;
         rsp_vld_ff  <= rsp_vld_in;
         valid_ff    <= valid_in;
         rd_valid_ff <= rd_valid_in;
         have_ff     <= have_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      obj_ff        <= obj_in;
      chunk_ff      <= chunk_in;
      bytes_ff      <= bytes_in;
      dirty_ff      <= dirty_in;
      locked_ff     <= locked_in;
      idx_ff        <= idx_in;
      best_idx_ff   <= best_idx_in;
      best_stamp_ff <= best_stamp_in;
      best_found_ff <= best_found_in;
      res_ff        <= res_in;
      rsp_ff        <= rsp_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_comb begin
      logic             adv;
      logic             done;
      logic             go_lru;
      logic             cand;
      logic [IDX_W-1:0] fin_idx;

      state_in      = state_ff;
      cmd_in        = cmd_ff;
      obj_in        = obj_ff;
      chunk_in      = chunk_ff;
      bytes_in      = bytes_ff;
      dirty_in      = dirty_ff;
      locked_in     = locked_ff;
      idx_in        = idx_ff;
      use_cnt_in    = use_cnt_ff;
      best_idx_in   = best_idx_ff;
      best_stamp_in = best_stamp_ff;
      best_found_in = best_found_ff;
      have_in       = have_ff;
      res_in        = res_ff;
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_word       = entry;
      push          = 1'b0;
      push_res      = res_ff;
      push_last     = 1'b1;
      req_tready    = 1'b0;
      adv           = 1'b1;
      done          = 1'b0;
      go_lru        = 1'b0;
      cand          = 1'b0;
      fin_idx       = best_idx_ff;

      unique case (state_ff)
         lwct_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd_in        = lwct_pkg::cmd_type'(req_tdata[2:0]);
               obj_in        = req_tdata[18:3];
               chunk_in      = req_tdata[38:19];
               bytes_in      = req_tdata[58:43];
               dirty_in      = req_tdata[59];
               locked_in     = req_tdata[60];
               idx_in        = '0;
               have_in       = 1'b0;
               best_found_in = 1'b0;
               res_in        = '0;
               res_in.status = lwct_pkg::ST_MISS;
               rd_en         = 1'b1;
               state_in      = lwct_pkg::S_SCAN;
               unique case (req_tdata[2:0]) inside
                  lwct_pkg::CMD_GET: begin
                     res_in.status = lwct_pkg::ST_FULL;
                  end
                  lwct_pkg::CMD_FLUSH_OBJ, lwct_pkg::CMD_FLUSH_ALL: begin
                     res_in.status = lwct_pkg::ST_OK;
                  end
                  lwct_pkg::CMD_UPDATE: begin
                     if ({3'b000, req_tdata[42:39]} < ENTRIES_L) begin
                        rd_addr  = sidx_ext[IDX_W-1:0];
                        idx_in   = sidx_ext[IDX_W-1:0];
                        state_in = lwct_pkg::S_UPD;
                     end else begin
                        rd_en    = 1'b0;
                        state_in = lwct_pkg::S_FIN;
                     end
                  end
                  lwct_pkg::CMD_FIND, lwct_pkg::CMD_INV_OBJ,
                  lwct_pkg::CMD_INV_CHUNK: begin
                     res_in.status = lwct_pkg::ST_MISS;
                  end
                  default: begin
                     rd_en    = 1'b0;
                     state_in = lwct_pkg::S_FIN;
                  end
               endcase
            end
         end

         lwct_pkg::S_SCAN: begin
            unique case (cmd_ff) inside
               lwct_pkg::CMD_FIND: begin
                  if (match.find_hit) begin
                     res_in        = '0;
                     res_in.status = lwct_pkg::ST_OK;
                     res_in.slot   = slot4(idx_ff);
                     res_in.object = entry.object;
                     res_in.chunk  = entry.chunk;
                     res_in.bytes  = entry.bytes;
                     done          = 1'b1;
                  end
               end
               lwct_pkg::CMD_GET: begin
                  if (match.key_eq) begin
                     wr_en         = 1'b1;
                     wr_word.stamp = cnt_inc;
                     use_cnt_in    = cnt_inc;
                     res_in        = '0;
                     res_in.status = lwct_pkg::ST_OK;
                     res_in.was_hit = 1'b1;
                     res_in.slot   = slot4(idx_ff);
                     res_in.object = entry.object;
                     res_in.chunk  = entry.chunk;
                     res_in.bytes  = entry.bytes;
                     done          = 1'b1;
                  end else if (idx_ff == LAST_IDX) begin
                     go_lru = 1'b1;
                  end
               end
               lwct_pkg::CMD_INV_OBJ, lwct_pkg::CMD_INV_CHUNK: begin
                  if (match.tag_eq && (cmd_ff == lwct_pkg::CMD_INV_OBJ || match.key_eq)) begin
                     wr_en          = 1'b1;
                     wr_word.object = '0;
                     wr_word.bytes  = '0;
                     wr_word.dirty  = 1'b0;
                     if (!have_ff) begin
                        have_in       = 1'b1;
                        res_in        = '0;
                        res_in.status = lwct_pkg::ST_OK;
                        res_in.slot   = slot4(idx_ff);
                     end
                     done = (cmd_ff == lwct_pkg::CMD_INV_CHUNK);
                  end
               end
               lwct_pkg::CMD_FLUSH_OBJ, lwct_pkg::CMD_FLUSH_ALL: begin
                  if (match.flush_hit) begin
                     if (have_ff && !free) begin
                        adv = 1'b0;
                     end else begin
                        wr_en         = 1'b1;
                        wr_word.dirty = 1'b0;
                        // the held item is not the last one: send it on
                        push      = have_ff;
                        push_last = 1'b0;
                        have_in   = 1'b1;
                        res_in            = '0;
                        res_in.status     = lwct_pkg::ST_OK;
                        res_in.slot       = slot4(idx_ff);
                        res_in.object     = entry.object;
                        res_in.chunk      = entry.chunk;
                        res_in.bytes      = entry.bytes;
                        res_in.flush_item = 1'b1;
                     end
                  end
               end
               default: begin
                  done = 1'b1;
               end
            endcase
            if (go_lru) begin
               rd_en    = 1'b1;
               rd_addr  = '0;
               idx_in   = '0;
               state_in = lwct_pkg::S_LRU;
            end else if (adv) begin
               if (done || idx_ff == LAST_IDX) begin
                  state_in = lwct_pkg::S_FIN;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = idx_nxt;
                  idx_in  = idx_nxt;
               end
            end
         end

         lwct_pkg::S_LRU: begin
            cand = match.evict_ok;
            if (cand) begin
               best_idx_in   = idx_ff;
               best_stamp_in = entry.stamp;
               best_found_in = 1'b1;
               fin_idx       = idx_ff;
            end
            if (idx_ff == LAST_IDX) begin
               state_in = lwct_pkg::S_FIN;
               if (cand || best_found_ff) begin
                  wr_en          = 1'b1;
                  wr_addr        = fin_idx;
                  wr_word        = '0;
                  wr_word.object = obj_ff;
                  wr_word.chunk  = chunk_ff;
                  wr_word.stamp  = cnt_inc;
                  use_cnt_in     = cnt_inc;
                  res_in         = '0;
                  res_in.status  = lwct_pkg::ST_OK;
                  res_in.slot    = slot4(fin_idx);
                  res_in.object  = obj_ff;
                  res_in.chunk   = chunk_ff;
               end
            end else begin
               rd_en   = 1'b1;
               rd_addr = idx_nxt;
               idx_in  = idx_nxt;
            end
         end

         lwct_pkg::S_UPD: begin
            wr_en          = 1'b1;
            wr_word.bytes  = bytes_ff;
            wr_word.dirty  = dirty_ff;
            wr_word.locked = locked_ff;
            res_in         = '0;
            res_in.status  = lwct_pkg::ST_OK;
            res_in.slot    = slot4(idx_ff);
            res_in.object  = entry.object;
            res_in.chunk   = entry.chunk;
            res_in.bytes   = bytes_ff;
            state_in       = lwct_pkg::S_FIN;
         end

         lwct_pkg::S_FIN: begin
            if (free) begin
               push     = 1'b1;
               state_in = lwct_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = lwct_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
      rd_valid_in = rd_en ? valid_ff[rd_addr] : rd_valid_ff;
      rsp_in      = rsp_ff;
      rsp_last_in = rsp_last_ff;
      rsp_vld_in  = rsp_vld_ff;
      if (push) begin
         rsp_in      = push_res;
         rsp_last_in = push_last;
         rsp_vld_in  = 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {5'b00000, rsp_ff.bytes, rsp_ff.chunk, rsp_ff.object,
                        rsp_ff.slot, rsp_ff.was_hit, rsp_ff.status};
   assign rsp_tuser  = rsp_ff.flush_item;
   assign rsp_tlast  = rsp_last_ff;

   // a result is only loaded when the output register can take it
   a_push_free: assert property (@(posedge clock) disable iff (reset)
      push |-> free)
      else $error("result pushed over a waiting result");

   // the table is never written while no request is in progress
   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == lwct_pkg::S_IDLE) |-> !wr_en)
      else $error("slot RAM written while idle");

   // valid bits only ever get set
   a_valid_grow: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ((valid_ff & $past(valid_ff)) == $past(valid_ff)))
      else $error("slot valid bit cleared");

   // the use counter moves only at the end of a get
   a_cnt_get_only: assert property (@(posedge clock) disable iff (reset)
      (cmd_ff != lwct_pkg::CMD_GET || state_ff == lwct_pkg::S_IDLE ||
       state_ff == lwct_pkg::S_FIN) |=> $stable(use_cnt_ff))
      else $error("use counter changed outside get");

endmodule
